// ===== rtl/sjis_key_candidate_enumerator_assert.svh =====
// Assertion macros for the Shift-JIS key candidate enumerator.
// Depends on nothing; included by the top level.
`ifndef SJIS_KEY_CANDIDATE_ENUMERATOR_ASSERT_SVH
`define SJIS_KEY_CANDIDATE_ENUMERATOR_ASSERT_SVH

// Checked property, disabled while reset is high.
`define SKCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property, also active during reset.
`define SKCE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/skce_pkg.sv =====
// Shared types, constants and functions of the Shift-JIS key candidate enumerator.
// Depends on nothing.
`default_nettype none

package skce_pkg;

   localparam int KEY_LEN   = 8;
   localparam int KEY_IDX_W = $clog2(KEY_LEN);
   localparam int KEY_CNT_W = $clog2(KEY_LEN + 1);
   localparam int OUT_KEY_BYTES = 8;

   localparam logic [14:0] GEN_MUL  = 15'd16807;
   localparam logic [31:0] GEN_MOD  = 32'd2147483647;
   localparam logic [8:0]  HIGH_BIT = 9'h080;
   localparam int DIV_STEPS = 31;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_APPEND = 2'd1,
      OP_RESEED = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_RESEED,
      MODE_ADVANCE,
      MODE_RESTART
   } mode_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REBUILD,
      ST_APP_RD,
      ST_APP_WR,
      ST_CTX,
      ST_RED,
      ST_SIZE,
      ST_DIV,
      ST_PL_E,
      ST_PL_B,
      ST_PL_TA,
      ST_PL_T,
      ST_ADV_E,
      ST_ADV_B,
      ST_ADV_C,
      ST_FIN
   } state_type;

   // Park-Miller step reduction: p mod (2^31 - 1) for p below 2^47.
   function automatic logic [31:0] gen_reduce(input logic [46:0] p);
      logic [31:0] s;
      s = {1'b0, p[30:0]} + {16'd0, p[46:31]};
      if (s >= GEN_MOD) begin
         s = s - GEN_MOD;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sjis_key_candidate_enumerator.sv =====
// Top level of the Shift-JIS key candidate enumerator: tables in memories, key sequencer.
// Depends on skce_pkg and sjis_key_candidate_enumerator_assert.svh.
//
// One request beat carries an opcode and its operands; every request gives one
// response beat with the eight key bytes and the exhausted and table_error flags.
// A load beat writes the byte type table and then rebuilds the base list by a
// sweep over all 256 bytes. An append beat reads the second-byte total and the
// pair flag and then writes them back. A reseed beat runs, per position, one
// generator step (multiply and reduce) and a bit-serial modulo of the 31 low
// generator bits by the list size. A next-key beat reads, through the single
// read port of each table memory, each position that it visits and each
// candidate before placing a byte, so long runs of skipped candidates lengthen it.
// After reset the block clears the pair map, the second-byte totals and the type
// table, one entry a cycle, and accepts no request meanwhile.
// The response sits in an output register: a new request is accepted while the
// previous response waits, but the sequencer holds its finished result until the
// register is free, so a stalled receiver stalls the block after one item.
`default_nettype none

module sjis_key_candidate_enumerator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[1:0], lead_byte[9:2], second_byte[17:10], char_type[19:18], seed[51:20]
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // key_byte_0..7[63:0], exhausted[64], table_error[65]
   output logic [71:0]      rsp_tdata
);

   localparam int IW = skce_pkg::KEY_IDX_W;
   localparam int CW = skce_pkg::KEY_CNT_W;
   localparam int KL = skce_pkg::KEY_LEN;

   logic [1:0]  type_mem [256];
   logic [7:0]  base_mem [256];
   logic [7:0]  sec_mem  [65536];
   logic [8:0]  tot_mem  [256];
   logic        pair_mem [65536];

   logic [1:0]  type_rd_ff;
   logic [7:0]  base_rd_ff;
   logic [7:0]  sec_rd_ff;
   logic [8:0]  tot_rd_ff;
   logic        pair_rd_ff;

   logic [7:0]  type_ra, type_wa;
   logic [1:0]  type_wd;
   logic        type_we;
   logic        base_we;
   logic [15:0] pair_ra, pair_wa;
   logic        pair_wd, pair_we;
   logic [7:0]  tot_wa;
   logic [8:0]  tot_wd;
   logic        tot_we;
   logic        sec_we;

   skce_pkg::state_type state_ff, state_in;
   skce_pkg::mode_type  mode_ff, mode_in;

   logic [15:0] clr_ff, clr_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [8:0]  base_total_ff, base_total_in;
   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  second_ff, second_in;
   logic [31:0] gen_ff, gen_in;
   logic [46:0] prod_ff, prod_in;
   logic [CW-1:0] n_ff, n_in;
   logic [8:0]  i_ff, i_in;
   logic [8:0]  size_ff, size_in;
   logic        usep_ff, usep_in;
   logic [1:0]  cur_type_ff, cur_type_in;
   logic [7:0]  floor_ff, floor_in;
   logic [7:0]  b_ff, b_in;
   logic [9:0]  rem_ff, rem_in;
   logic [30:0] dv_ff, dv_in;
   logic        err_ff, err_in;
   logic        done_ff, done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   logic [8:0]  pidx_ff   [KL];
   logic [8:0]  pidx_in   [KL];
   logic [7:0]  pbyte_ff  [KL];
   logic [7:0]  pbyte_in  [KL];
   logic [1:0]  ptype_ff  [KL];
   logic [1:0]  ptype_in  [KL];
   logic [7:0]  pfloor_ff [KL];
   logic [7:0]  pfloor_in [KL];

   logic [IW-1:0] pn, pm1;
   logic [7:0]  entry;
   logic [8:0]  size_now;
   logic [9:0]  div_t;
   logic        rep;
   logic        req_acc;
   logic [1:0]  new_type;

   assign pn       = n_ff[IW-1:0];
   assign pm1      = pn - 1'b1;
   assign entry    = usep_ff ? sec_rd_ff : base_rd_ff;
   assign size_now = usep_ff ? tot_rd_ff : base_total_ff;
   assign div_t    = {rem_ff[8:0], dv_ff[30]};
   assign rep      = ({1'b0, b_ff} >= ({1'b0, floor_ff} + skce_pkg::HIGH_BIT)) &&
                     (usep_ff ? pair_rd_ff : (type_rd_ff == cur_type_ff));
   assign new_type = usep_ff ? 2'd1 : type_rd_ff;
   assign req_acc  = req_tvalid && req_tready;

   assign req_tready = (state_ff == skce_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Memory address and write selection.
   always_comb begin
      type_ra = b_ff;
      pair_ra = {lead_ff, second_ff};
      unique case (state_ff)
         skce_pkg::ST_REBUILD: type_ra = cnt_ff[7:0];
         skce_pkg::ST_ADV_B: begin
            type_ra = {1'b0, entry[6:0]};
            pair_ra = {lead_ff, 1'b0, entry[6:0]};
         end
         default: ;
      endcase
      type_we = (state_ff == skce_pkg::ST_CLEAR) ||
                (req_acc && (req_tdata[1:0] == skce_pkg::OP_LOAD));
      type_wa = (state_ff == skce_pkg::ST_CLEAR) ? clr_ff[7:0] : req_tdata[9:2];
      type_wd = (state_ff == skce_pkg::ST_CLEAR) ? 2'd0 : req_tdata[19:18];
      base_we = (state_ff == skce_pkg::ST_REBUILD) && (cnt_ff != 9'd0) &&
                (type_rd_ff != 2'd0);
      sec_we  = (state_ff == skce_pkg::ST_APP_WR) && !tot_rd_ff[8] && !pair_rd_ff;
      pair_we = (state_ff == skce_pkg::ST_CLEAR) || sec_we;
      pair_wa = (state_ff == skce_pkg::ST_CLEAR) ? clr_ff : {lead_ff, second_ff};
      pair_wd = (state_ff != skce_pkg::ST_CLEAR);
      tot_we  = pair_we;
      tot_wa  = (state_ff == skce_pkg::ST_CLEAR) ? clr_ff[7:0] : lead_ff;
      tot_wd  = (state_ff == skce_pkg::ST_CLEAR) ? 9'd0 : (tot_rd_ff + 9'd1);
   end

   always_ff @(posedge clock) begin
      type_rd_ff <= type_mem[type_ra];
      if (type_we) begin
         type_mem[type_wa] <= type_wd;
      end
      base_rd_ff <= base_mem[i_ff[7:0]];
      if (base_we) begin
         base_mem[base_total_ff[7:0]] <= 8'(cnt_ff - 9'd1);
      end
      sec_rd_ff <= sec_mem[{lead_ff, i_ff[7:0]}];
      if (sec_we) begin
         sec_mem[{lead_ff, tot_rd_ff[7:0]}] <= second_ff;
      end
      tot_rd_ff <= tot_mem[lead_ff];
      if (tot_we) begin
         tot_mem[tot_wa] <= tot_wd;
      end
      pair_rd_ff <= pair_mem[pair_ra];
      if (pair_we) begin
         pair_mem[pair_wa] <= pair_wd;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      base_total_in = base_total_ff;
      lead_in       = lead_ff;
      second_in     = second_ff;
      gen_in        = gen_ff;
      prod_in       = {15'd0, gen_ff} * {32'd0, skce_pkg::GEN_MUL};
      n_in          = n_ff;
      i_in          = i_ff;
      size_in       = size_ff;
      usep_in       = usep_ff;
      cur_type_in   = cur_type_ff;
      floor_in      = floor_ff;
      b_in          = b_ff;
      rem_in        = rem_ff;
      dv_in         = dv_ff;
      err_in        = err_ff;
      done_in       = done_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      pidx_in       = pidx_ff;
      pbyte_in      = pbyte_ff;
      ptype_in      = ptype_ff;
      pfloor_in     = pfloor_ff;

      unique case (state_ff)
         skce_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 16'd1;
            if (clr_ff == 16'hFFFF) begin
               state_in = skce_pkg::ST_IDLE;
            end
         end
         skce_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               lead_in   = req_tdata[9:2];
               second_in = req_tdata[17:10];
               err_in    = 1'b0;
               done_in   = 1'b0;
               unique case (skce_pkg::op_type'(req_tdata[1:0]))
                  skce_pkg::OP_LOAD: begin
                     cnt_in        = 9'd0;
                     base_total_in = 9'd0;
                     state_in      = skce_pkg::ST_REBUILD;
                  end
                  skce_pkg::OP_APPEND: state_in = skce_pkg::ST_APP_RD;
                  skce_pkg::OP_RESEED: begin
                     gen_in   = req_tdata[51:20];
                     n_in     = '0;
                     mode_in  = skce_pkg::MODE_RESEED;
                     state_in = skce_pkg::ST_CTX;
                  end
                  skce_pkg::OP_NEXT: begin
                     n_in     = CW'(KL - 1);
                     mode_in  = skce_pkg::MODE_ADVANCE;
                     state_in = skce_pkg::ST_CTX;
                  end
               endcase
            end
         end
         skce_pkg::ST_REBUILD: begin
            if (base_we) begin
               base_total_in = base_total_ff + 9'd1;
            end
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd256) begin
               state_in = skce_pkg::ST_FIN;
            end
         end
         skce_pkg::ST_APP_RD: state_in = skce_pkg::ST_APP_WR;
         skce_pkg::ST_APP_WR: state_in = skce_pkg::ST_FIN;
         skce_pkg::ST_CTX: begin
            usep_in = (n_ff != '0) && ptype_ff[pm1][1];
            lead_in = pbyte_ff[pm1];
            if (mode_ff == skce_pkg::MODE_ADVANCE) begin
               i_in        = pidx_ff[pn] + 9'd1;
               cur_type_in = ptype_ff[pn];
               floor_in    = pfloor_ff[pn];
            end else begin
               i_in = 9'd0;
            end
            state_in = skce_pkg::ST_RED;
         end
         skce_pkg::ST_RED: begin
            if (mode_ff == skce_pkg::MODE_RESEED) begin
               gen_in = skce_pkg::gen_reduce(prod_ff);
            end
            state_in = skce_pkg::ST_SIZE;
         end
         skce_pkg::ST_SIZE: begin
            size_in = size_now;
            if (mode_ff == skce_pkg::MODE_ADVANCE) begin
               if (i_ff < size_now) begin
                  state_in = skce_pkg::ST_ADV_E;
               end else if (n_ff == CW'(1)) begin
                  done_in  = 1'b1;
                  mode_in  = skce_pkg::MODE_RESTART;
                  state_in = skce_pkg::ST_CTX;
               end else begin
                  n_in     = n_ff - 1'b1;
                  state_in = skce_pkg::ST_CTX;
               end
            end else if (size_now == 9'd0) begin
               pidx_in[pn]   = 9'd0;
               pbyte_in[pn]  = 8'd0;
               ptype_in[pn]  = 2'd0;
               pfloor_in[pn] = 8'd0;
               err_in        = 1'b1;
               n_in          = n_ff + 1'b1;
               state_in      = (n_ff == CW'(KL - 1)) ? skce_pkg::ST_FIN : skce_pkg::ST_CTX;
            end else if (mode_ff == skce_pkg::MODE_RESEED) begin
               rem_in   = 10'd0;
               dv_in    = gen_ff[30:0];
               cnt_in   = 9'd0;
               state_in = skce_pkg::ST_DIV;
            end else begin
               state_in = skce_pkg::ST_PL_E;
            end
         end
         skce_pkg::ST_DIV: begin
            rem_in = (div_t >= {1'b0, size_ff}) ? (div_t - {1'b0, size_ff}) : div_t;
            dv_in  = {dv_ff[29:0], 1'b0};
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'(skce_pkg::DIV_STEPS - 1)) begin
               i_in     = rem_in[8:0];
               state_in = skce_pkg::ST_PL_E;
            end
         end
         skce_pkg::ST_PL_E: state_in = skce_pkg::ST_PL_B;
         skce_pkg::ST_PL_B: begin
            b_in     = entry;
            state_in = skce_pkg::ST_PL_TA;
         end
         skce_pkg::ST_PL_TA: state_in = skce_pkg::ST_PL_T;
         skce_pkg::ST_PL_T: begin
            pidx_in[pn]  = i_ff;
            pbyte_in[pn] = b_ff;
            ptype_in[pn] = new_type;
            if (mode_ff == skce_pkg::MODE_RESEED) begin
               pfloor_in[pn] = b_ff;
            end else if (mode_ff == skce_pkg::MODE_RESTART) begin
               pfloor_in[pn] = 8'd0;
            end
            if (mode_ff == skce_pkg::MODE_ADVANCE) begin
               mode_in = skce_pkg::MODE_RESTART;
            end
            n_in     = n_ff + 1'b1;
            state_in = (n_ff == CW'(KL - 1)) ? skce_pkg::ST_FIN : skce_pkg::ST_CTX;
         end
         skce_pkg::ST_ADV_E: state_in = skce_pkg::ST_ADV_B;
         skce_pkg::ST_ADV_B: begin
            b_in     = entry;
            state_in = skce_pkg::ST_ADV_C;
         end
         skce_pkg::ST_ADV_C: begin
            if (!rep) begin
               state_in = skce_pkg::ST_PL_TA;
            end else begin
               i_in = i_ff + 9'd1;
               if ((i_ff + 9'd1) < size_ff) begin
                  state_in = skce_pkg::ST_ADV_E;
               end else if (n_ff == CW'(1)) begin
                  done_in  = 1'b1;
                  mode_in  = skce_pkg::MODE_RESTART;
                  state_in = skce_pkg::ST_CTX;
               end else begin
                  n_in     = n_ff - 1'b1;
                  state_in = skce_pkg::ST_CTX;
               end
            end
         end
         skce_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = '0;
               for (int k = 0; k < skce_pkg::OUT_KEY_BYTES; k++) begin
                  if (k < KL) begin
                     rsp_data_in[8*k +: 8] = pbyte_ff[k];
                  end
               end
               rsp_data_in[64] = done_ff;
               rsp_data_in[65] = err_ff;
               rsp_valid_in    = 1'b1;
               state_in        = skce_pkg::ST_IDLE;
            end
         end
         default: state_in = skce_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= skce_pkg::ST_CLEAR;
         mode_ff       <= skce_pkg::MODE_RESEED;
         clr_ff        <= 16'd0;
         base_total_ff <= 9'd0;
         gen_ff        <= 32'd0;
         n_ff          <= '0;
         err_ff        <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < KL; k++) begin
            pidx_ff[k]   <= 9'd0;
            pbyte_ff[k]  <= 8'd0;
            ptype_ff[k]  <= 2'd0;
            pfloor_ff[k] <= 8'd0;
         end
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         clr_ff        <= clr_in;
         base_total_ff <= base_total_in;
         gen_ff        <= gen_in;
         n_ff          <= n_in;
         err_ff        <= err_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
         pidx_ff       <= pidx_in;
         pbyte_ff      <= pbyte_in;
         ptype_ff      <= ptype_in;
         pfloor_ff     <= pfloor_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      lead_ff     <= lead_in;
      second_ff   <= second_in;
      prod_ff     <= prod_in;
      i_ff        <= i_in;
      size_ff     <= size_in;
      usep_ff     <= usep_in;
      cur_type_ff <= cur_type_in;
      floor_ff    <= floor_in;
      b_ff        <= b_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "sjis_key_candidate_enumerator_assert.svh"

   `SKCE_ASSERT_ALWAYS(a_no_accept_in_clear, (state_ff == skce_pkg::ST_CLEAR) |-> !req_tready, "request accepted during clearing pass")
   `SKCE_ASSERT(a_accept_leaves_idle, req_acc |=> (state_ff != skce_pkg::ST_IDLE), "accepted beat did not start work")
   `SKCE_ASSERT(a_div_nonzero, (state_ff == skce_pkg::ST_DIV) |-> (size_ff != 9'd0), "modulo by an empty list size")
   `SKCE_ASSERT(a_pos_in_range, (state_ff == skce_pkg::ST_PL_T) |-> (n_ff < CW'(KL)), "key position out of range")

endmodule

`default_nettype wire

// ===== tb/sjis_key_candidate_checker.sv =====
// Checker for the Shift-JIS key candidate enumerator: watches both streams, predicts
// every response beat from the accepted request beats and compares them field by field.
// Depends on skce_pkg.
`default_nettype none

module sjis_key_candidate_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] key [8];
      logic       exhausted;
      logic       table_error;
   } key_result_type;

   key_result_type key_queue [$];

   logic [1:0] type_of    [256];
   logic [7:0] base_bytes [256];
   logic [8:0] base_total;
   logic [7:0] seconds    [65536];
   logic [8:0] second_total [256];
   logic       pair_seen  [65536];
   logic [31:0] gen;
   logic [8:0] pos_idx   [8];
   logic [7:0] pos_byte  [8];
   logic [1:0] pos_type  [8];
   logic [7:0] pos_floor [8];

   function automatic bit from_pairs(int n);
      return n > 0 && pos_type[n - 1] >= 2'd2;
   endfunction

   function automatic logic [8:0] list_len(int n);
      return from_pairs(n) ? second_total[pos_byte[n - 1]] : base_total;
   endfunction

   function automatic logic [7:0] list_at(int n, logic [8:0] i);
      return from_pairs(n) ? seconds[{pos_byte[n - 1], i[7:0]}] : base_bytes[i[7:0]];
   endfunction

   function automatic bit repeats(int n, logic [7:0] b);
      logic [7:0] low;
      if ({1'b0, b} < {1'b0, pos_floor[n]} + 9'h080) return 1'b0;
      low = b - 8'h80;
      if (from_pairs(n)) return pair_seen[{pos_byte[n - 1], low}];
      return type_of[low] == pos_type[n];
   endfunction

   function automatic void put(int n, logic [8:0] i, logic [7:0] b);
      pos_idx[n] = i;
      pos_byte[n] = b;
      pos_type[n] = from_pairs(n) ? 2'd1 : type_of[b];
   endfunction

   task automatic clear_pos(int n);
      pos_idx[n] = '0;
      pos_byte[n] = '0;
      pos_type[n] = '0;
      pos_floor[n] = '0;
   endtask

   function automatic bit step_pos(int n);
      int size;
      int i;
      size = list_len(n);
      for (i = pos_idx[n] + 1; i < size; i++) begin
         if (!repeats(n, list_at(n, i[8:0]))) begin
            put(n, i[8:0], list_at(n, i[8:0]));
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic predict_key(input logic [55:0] d, output key_result_type r);
      skce_pkg::op_type op;
      logic [7:0]  lead;
      logic [7:0]  sec;
      logic [1:0]  ct;
      logic [63:0] prod;
      logic [8:0]  size;
      logic [8:0]  idx;
      int          n;
      int          total;
      op = skce_pkg::op_type'(d[1:0]);
      lead = d[9:2];
      sec = d[17:10];
      ct = d[19:18];
      r.exhausted = 1'b0;
      r.table_error = 1'b0;
      case (op)
         skce_pkg::OP_LOAD: begin
            type_of[lead] = ct;
            total = 0;
            for (int b = 0; b < 256; b++) begin
               if (type_of[b] != 2'd0) begin
                  base_bytes[total] = b[7:0];
                  total++;
               end
            end
            base_total = total[8:0];
         end
         skce_pkg::OP_APPEND: begin
            if (second_total[lead] < 9'd256 && !pair_seen[{lead, sec}]) begin
               pair_seen[{lead, sec}] = 1'b1;
               seconds[{lead, second_total[lead][7:0]}] = sec;
               second_total[lead] = second_total[lead] + 9'd1;
            end
         end
         skce_pkg::OP_RESEED: begin
            gen = d[51:20];
            for (n = 0; n < skce_pkg::KEY_LEN; n++) begin
               prod = 64'd16807 * gen;
               gen = 32'(prod % 64'd2147483647);
               size = list_len(n);
               if (size == 9'd0) begin
                  clear_pos(n);
                  r.table_error = 1'b1;
               end else begin
                  idx = 9'(gen % size);
                  put(n, idx, list_at(n, idx));
                  pos_floor[n] = pos_byte[n];
               end
            end
         end
         default: begin
            n = skce_pkg::KEY_LEN - 1;
            while (n >= 1 && !step_pos(n)) n--;
            if (n < 1) begin
               r.exhausted = 1'b1;
               n = 0;
            end
            for (int k = n + 1; k < skce_pkg::KEY_LEN; k++) begin
               if (list_len(k) == 9'd0) begin
                  clear_pos(k);
                  r.table_error = 1'b1;
               end else begin
                  pos_floor[k] = '0;
                  put(k, 9'd0, list_at(k, 9'd0));
               end
            end
         end
      endcase
      for (int k = 0; k < 8; k++) r.key[k] = pos_byte[k];
   endtask

   initial begin
      foreach (type_of[i]) type_of[i] = '0;
      foreach (second_total[i]) second_total[i] = '0;
      foreach (pair_seen[i]) pair_seen[i] = 1'b0;
      foreach (pos_idx[i]) clear_pos(i);
      base_total = '0;
      gen = '0;
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      key_result_type exp_r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_key(req_tdata, exp_r);
            key_queue.push_back(exp_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (key_queue.size() == 0) begin
               $display("%0t: response beat with none expected, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               exp_r = key_queue.pop_front();
               for (int k = 0; k < 8; k++) begin
                  if (rsp_tdata[8*k +: 8] !== exp_r.key[k]) begin
                     $display("%0t: key_byte_%0d expected %h actual %h", $time, k,
                        exp_r.key[k], rsp_tdata[8*k +: 8]);
                     fail_count++;
                  end
               end
               if (rsp_tdata[64] !== exp_r.exhausted) begin
                  $display("%0t: exhausted expected %b actual %b", $time,
                     exp_r.exhausted, rsp_tdata[64]);
                  fail_count++;
               end
               if (rsp_tdata[65] !== exp_r.table_error) begin
                  $display("%0t: table_error expected %b actual %b", $time,
                     exp_r.table_error, rsp_tdata[65]);
                  fail_count++;
               end
            end
         end
         pending = key_queue.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench top of the Shift-JIS key candidate enumerator: clock, reset, request
// stimulus under several idling phases, watchdog and verdict.
// Depends on skce_pkg, sjis_key_candidate_enumerator and sjis_key_candidate_checker.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          gap_pct = 0;
   int          stall_pct = 0;
   int          idle_cycles = 0;
   int          op_count [4] = '{0, 0, 0, 0};

   sjis_key_candidate_enumerator u_top (.*);

   sjis_key_candidate_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send(skce_pkg::op_type op, logic [7:0] lead, logic [7:0] sec,
                       logic [1:0] ct, logic [31:0] seed);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {4'd0, seed, ct, sec, lead, op};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      op_count[op]++;
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] u;
      if ($urandom_range(99) < 15) return 8'($urandom);
      u = 8'h40 + 8'($urandom_range(11));
      return $urandom_range(1) ? u : u + 8'h80;
   endfunction

   task automatic random_beat();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         send(skce_pkg::OP_LOAD, pick_byte(), 8'($urandom), 2'($urandom), $urandom);
      end else if (r < 25) begin
         send(skce_pkg::OP_APPEND, pick_byte(), pick_byte(), 2'($urandom), $urandom);
      end else if (r < 33) begin
         send(skce_pkg::OP_RESEED, 8'($urandom), 8'($urandom), 2'($urandom), $urandom);
      end else begin
         send(skce_pkg::OP_NEXT, 8'($urandom), 8'($urandom), 2'($urandom), $urandom);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty tables first, then a small table with removal, pairs and repeats.
      send(skce_pkg::OP_RESEED, 8'h00, 8'h00, 2'd0, 32'd0);
      send(skce_pkg::OP_NEXT, 8'h00, 8'h00, 2'd0, 32'd0);
      send(skce_pkg::OP_LOAD, 8'h00, 8'h00, 2'd1, 32'd0);
      send(skce_pkg::OP_LOAD, 8'hFF, 8'hFF, 2'd2, 32'hFFFFFFFF);
      send(skce_pkg::OP_LOAD, 8'h7F, 8'h00, 2'd3, 32'd0);
      send(skce_pkg::OP_LOAD, 8'h80, 8'h00, 2'd1, 32'd0);
      send(skce_pkg::OP_LOAD, 8'h40, 8'h00, 2'd2, 32'd0);
      send(skce_pkg::OP_LOAD, 8'hC0, 8'h00, 2'd2, 32'd0);
      send(skce_pkg::OP_APPEND, 8'hFF, 8'h00, 2'd0, 32'd0);
      send(skce_pkg::OP_APPEND, 8'hFF, 8'hFF, 2'd0, 32'd0);
      send(skce_pkg::OP_APPEND, 8'hFF, 8'h40, 2'd0, 32'd0);
      send(skce_pkg::OP_APPEND, 8'hFF, 8'hC0, 2'd0, 32'd0);
      send(skce_pkg::OP_APPEND, 8'hFF, 8'h40, 2'd3, 32'd0);
      send(skce_pkg::OP_RESEED, 8'h00, 8'h00, 2'd0, 32'hFFFFFFFF);
      repeat (3) send(skce_pkg::OP_NEXT, 8'h00, 8'h00, 2'd0, 32'd0);
      send(skce_pkg::OP_LOAD, 8'h7F, 8'h00, 2'd0, 32'd0);
      send(skce_pkg::OP_RESEED, 8'h00, 8'h00, 2'd0, 32'h7FFFFFFF);
      send(skce_pkg::OP_RESEED, 8'h00, 8'h00, 2'd0, 32'd1);
      repeat (4) send(skce_pkg::OP_NEXT, 8'hFF, 8'hFF, 2'd3, 32'hFFFFFFFF);

      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 13) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 85 : 13) : 0;
         if (ph == 2) begin
            // Fill one lead byte's second-byte list completely, then overflow it.
            send(skce_pkg::OP_LOAD, 8'h81, 8'h00, 2'd2, 32'd0);
            for (int s = 0; s < 256; s++)
               send(skce_pkg::OP_APPEND, 8'h81, 8'(s), 2'd0, 32'd0);
            send(skce_pkg::OP_APPEND, 8'h81, 8'h55, 2'd0, 32'd0);
         end
         repeat (ph == 2 ? 160 : 500) random_beat();
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      wait (pending == 0);
      repeat (1000) @(posedge clock);
      $display("Beats sent: %0d loads, %0d appends, %0d reseeds, %0d next-key steps.",
         op_count[skce_pkg::OP_LOAD], op_count[skce_pkg::OP_APPEND],
         op_count[skce_pkg::OP_RESEED], op_count[skce_pkg::OP_NEXT]);
      $display("Idling phases covered: none, sender gaps, receiver stalls, both.");
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/skce_pkg.sv
rtl/sjis_key_candidate_enumerator.sv
tb/sjis_key_candidate_checker.sv
tb/tb.sv
